[design/clp_pkg.sv]
`default_nettype none

package clp_pkg;

    // widths of the result fields and length of the header keyword
    localparam int VAR_INDEX_BITS = 28;
    localparam int ACC_BITS       = 31;
    localparam int LINE_BITS      = 32;
    localparam int HDR_LEN        = 5;

    localparam logic [ACC_BITS-1:0] ACC_MAX   = {ACC_BITS{1'b1}};
    // a literal value above this gives an index out of range
    localparam logic [ACC_BITS:0]   VAR_LIMIT = (ACC_BITS+1)'(1) << VAR_INDEX_BITS;

    // byte classes seen by the parser
    typedef enum logic [3:0] {
        CC_EOI,
        CC_BLANK,
        CC_SPACE,
        CC_NL,
        CC_DIGIT,
        CC_MINUS,
        CC_PLUS,
        CC_P,
        CC_C,
        CC_N,
        CC_F,
        CC_X,
        CC_OTHER
    } t_char_class;

    typedef enum logic [2:0] {
        KIND_LITERAL     = 3'd0,
        KIND_CLAUSE_END  = 3'd1,
        KIND_HDR_VARS    = 3'd2,
        KIND_HDR_CLAUSES = 3'd3,
        KIND_ERROR       = 3'd4,
        KIND_CLEAN_END   = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NUMBER    = 2'd0,
        ERR_VAR_RANGE = 2'd1,
        ERR_HEADER    = 2'd2,
        ERR_XOR       = 2'd3
    } t_err;

    // classified byte between front and back
    typedef struct packed {
        t_char_class cls;
        logic [3:0]  digit;
    } t_item;

    typedef struct packed {
        t_kind                     kind;
        logic [VAR_INDEX_BITS-1:0] var_index;
        logic                      negated;
        logic [ACC_BITS-1:0]       count_value;
        t_err                      error_code;
        logic [LINE_BITS-1:0]      line_number;
        logic                      last;
    } t_result;

    // queue side of the front/back split
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

endpackage

`default_nettype wire

[design/clp_in_if.sv]
`default_nettype none

interface clp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_input;

    modport source (output valid, output char_code, output end_of_input, input ready);
    modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

`default_nettype wire

[design/clp_out_if.sv]
`default_nettype none

interface clp_out_if;
    logic                               valid;
    logic                               ready;
    logic [2:0]                         kind;
    logic [clp_pkg::VAR_INDEX_BITS-1:0] var_index;
    logic                               negated;
    logic [clp_pkg::ACC_BITS-1:0]       count_value;
    logic [1:0]                         error_code;
    logic [clp_pkg::LINE_BITS-1:0]      line_number;
    logic                               last;

    modport source (
        output valid, output kind, output var_index, output negated,
        output count_value, output error_code, output line_number, output last,
        input ready
    );
    modport sink (
        input valid, input kind, input var_index, input negated,
        input count_value, input error_code, input line_number, input last,
        output ready
    );
endinterface

`default_nettype wire

[design/clp_front.sv]
`default_nettype none

module clp_front (
    clp_in_if.sink          i_in,
    input  wire logic       i_q_ready,
    output logic            o_push,
    output clp_pkg::t_item  o_item
);

    // accept whenever the queue has room
    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid && i_q_ready;

    // byte classification
    always_comb begin
        o_item.digit = 4'd0;
        if (i_in.end_of_input) begin
            o_item.cls = clp_pkg::CC_EOI;
        end else begin
            unique case (i_in.char_code) inside
                8'd9, 8'd11, 8'd12, 8'd13: o_item.cls = clp_pkg::CC_BLANK;
                8'd32:                     o_item.cls = clp_pkg::CC_SPACE;
                8'd10:                     o_item.cls = clp_pkg::CC_NL;
                [8'h30:8'h39]: begin
                    o_item.cls   = clp_pkg::CC_DIGIT;
                    o_item.digit = i_in.char_code[3:0];
                end
                8'h2d:                     o_item.cls = clp_pkg::CC_MINUS;
                8'h2b:                     o_item.cls = clp_pkg::CC_PLUS;
                8'h70:                     o_item.cls = clp_pkg::CC_P;
                8'h63:                     o_item.cls = clp_pkg::CC_C;
                8'h6e:                     o_item.cls = clp_pkg::CC_N;
                8'h66:                     o_item.cls = clp_pkg::CC_F;
                8'h78:                     o_item.cls = clp_pkg::CC_X;
                default:                   o_item.cls = clp_pkg::CC_OTHER;
            endcase
        end
    end

endmodule

`default_nettype wire

[design/clp_queue.sv]
`default_nettype none

module clp_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire clp_pkg::t_item   i_item,
    output logic                  o_ready,
    input  wire logic             i_pop,
    output clp_pkg::t_q_head      o_head
);

    clp_pkg::t_item r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    assign o_ready     = (r_count != 2'd2);
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_mem[r_rd_ptr];

    // two-entry fifo storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

[design/clp_back.sv]
`default_nettype none

module clp_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire clp_pkg::t_q_head i_head,
    output logic                  o_pop,
    clp_out_if.source             o_out
);

    typedef enum logic [3:0] {
        M_LINE,
        M_HDR_MATCH,
        M_HDR_PRE,
        M_HDR_SIGNED,
        M_HDR_DIGITS,
        M_CL_PRE,
        M_CL_SIGNED,
        M_CL_DIGITS,
        M_SKIP
    } t_mode;

    localparam int VB = clp_pkg::VAR_INDEX_BITS;
    localparam int AB = clp_pkg::ACC_BITS;
    localparam int LB = clp_pkg::LINE_BITS;

    // parser state
    t_mode               r_mode;
    logic [AB-1:0]       r_acc;
    logic                r_neg;
    logic [2:0]          r_pos;
    logic                r_second;
    logic [LB-1:0]       r_line;
    logic                r_halted;

    // output register and second-result hold
    clp_pkg::t_result    r_out;
    logic                r_out_valid;
    clp_pkg::t_result    r_pend;
    logic                r_pend_valid;

    // next values
    t_mode               n_mode;
    logic [AB-1:0]       n_acc;
    logic                n_neg;
    logic [2:0]          n_pos;
    logic                n_second;
    logic [LB-1:0]       n_line;
    logic                n_halted;
    clp_pkg::t_result    n_r0;
    clp_pkg::t_result    n_r1;
    logic [1:0]          n_count;

    logic                take;
    logic                can_take;

    function automatic clp_pkg::t_result make_res(
        clp_pkg::t_kind kind,
        logic [VB-1:0]  var_index,
        logic           negated,
        logic [AB-1:0]  count_value,
        clp_pkg::t_err  error_code,
        logic [LB-1:0]  line_number
    );
        clp_pkg::t_result res;
        res.kind        = kind;
        res.var_index   = var_index;
        res.negated     = negated;
        res.count_value = count_value;
        res.error_code  = error_code;
        res.line_number = line_number;
        res.last        = 1'b0;
        return res;
    endfunction

    // one byte: up to two passes, the second when a number ends or a clause opens on this byte
    always_comb begin
        clp_pkg::t_char_class cls;
        logic [3:0]           dig;
        logic                 again;
        logic                 emit;
        logic                 hdr;
        logic                 match;
        clp_pkg::t_result     res;
        logic [AB+3:0]        sum;
        logic [AB-1:0]        var_full;

        cls      = i_head.item.cls;
        dig      = i_head.item.digit;
        n_mode   = r_mode;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_pos    = r_pos;
        n_second = r_second;
        n_line   = r_line;
        n_halted = r_halted;
        n_r0     = '0;
        n_r1     = '0;
        n_count  = 2'd0;
        again    = 1'b0;
        emit     = 1'b0;
        hdr      = 1'b0;
        match    = 1'b0;
        res      = '0;
        sum      = '0;
        var_full = '0;

        for (int p = 0; p < 2; p++) begin
            if (!n_halted && (p == 0 || again)) begin
                again = 1'b0;
                emit  = 1'b0;
                hdr   = (n_mode == M_HDR_PRE) || (n_mode == M_HDR_SIGNED)
                        || (n_mode == M_HDR_DIGITS);
                unique case (n_mode)
                    M_LINE: begin
                        if (cls == clp_pkg::CC_EOI) begin
                            res = make_res(clp_pkg::KIND_CLEAN_END, '0, 1'b0, '0,
                                           clp_pkg::ERR_NUMBER, n_line + 1'b1);
                            emit     = 1'b1;
                            n_halted = 1'b1;
                        end else if (cls == clp_pkg::CC_BLANK
                                     || cls == clp_pkg::CC_SPACE) begin
                            n_mode = M_LINE;
                        end else if (cls == clp_pkg::CC_NL) begin
                            n_line = n_line + 1'b1;
                        end else if (cls == clp_pkg::CC_P) begin
                            n_mode = M_HDR_MATCH;
                            n_pos  = 3'd1;
                        end else if (cls == clp_pkg::CC_C) begin
                            n_mode = M_SKIP;
                        end else if (cls == clp_pkg::CC_X) begin
                            res = make_res(clp_pkg::KIND_ERROR, '0, 1'b0, '0,
                                           clp_pkg::ERR_XOR, n_line + 1'b1);
                            emit     = 1'b1;
                            n_halted = 1'b1;
                        end else begin
                            // any other byte opens a clause
                            n_mode = M_CL_PRE;
                            n_acc  = '0;
                            n_neg  = 1'b0;
                            again  = 1'b1;
                        end
                    end
                    M_HDR_MATCH: begin
                        match = (n_pos == 3'd1 && cls == clp_pkg::CC_SPACE)
                             || (n_pos == 3'd2 && cls == clp_pkg::CC_C)
                             || (n_pos == 3'd3 && cls == clp_pkg::CC_N)
                             || (n_pos == 3'd4 && cls == clp_pkg::CC_F);
                        if (!match) begin
                            res = make_res(clp_pkg::KIND_ERROR, '0, 1'b0, '0,
                                           clp_pkg::ERR_HEADER, n_line + 1'b1);
                            emit     = 1'b1;
                            n_halted = 1'b1;
                        end else if (n_pos == 3'(clp_pkg::HDR_LEN - 1)) begin
                            n_pos    = 3'd0;
                            n_second = 1'b0;
                            n_acc    = '0;
                            n_neg    = 1'b0;
                            n_mode   = M_HDR_PRE;
                        end else begin
                            n_pos = n_pos + 3'd1;
                        end
                    end
                    M_HDR_PRE, M_CL_PRE: begin
                        if (cls == clp_pkg::CC_BLANK || cls == clp_pkg::CC_SPACE) begin
                            n_mode = n_mode;
                        end else if (cls == clp_pkg::CC_MINUS
                                     || cls == clp_pkg::CC_PLUS) begin
                            n_neg  = (cls == clp_pkg::CC_MINUS);
                            n_mode = hdr ? M_HDR_SIGNED : M_CL_SIGNED;
                        end else if (cls == clp_pkg::CC_DIGIT) begin
                            n_acc  = AB'(dig);
                            n_mode = hdr ? M_HDR_DIGITS : M_CL_DIGITS;
                        end else begin
                            res = make_res(clp_pkg::KIND_ERROR, '0, 1'b0, '0,
                                           clp_pkg::ERR_NUMBER, n_line + 1'b1);
                            emit     = 1'b1;
                            n_halted = 1'b1;
                        end
                    end
                    M_HDR_SIGNED, M_CL_SIGNED: begin
                        if (cls == clp_pkg::CC_DIGIT) begin
                            n_acc  = AB'(dig);
                            n_mode = hdr ? M_HDR_DIGITS : M_CL_DIGITS;
                        end else begin
                            res = make_res(clp_pkg::KIND_ERROR, '0, 1'b0, '0,
                                           clp_pkg::ERR_NUMBER, n_line + 1'b1);
                            emit     = 1'b1;
                            n_halted = 1'b1;
                        end
                    end
                    M_HDR_DIGITS, M_CL_DIGITS: begin
                        if (cls == clp_pkg::CC_DIGIT) begin
                            // acc * 10 + digit, saturating
                            sum = ({4'd0, n_acc} << 3) + ({4'd0, n_acc} << 1)
                                  + (AB+4)'(dig);
                            n_acc = (sum > (AB+4)'(clp_pkg::ACC_MAX))
                                    ? clp_pkg::ACC_MAX : sum[AB-1:0];
                        end else begin
                            if (hdr) begin
                                res = make_res(n_second ? clp_pkg::KIND_HDR_CLAUSES
                                                        : clp_pkg::KIND_HDR_VARS,
                                               '0, 1'b0, n_neg ? '0 : n_acc,
                                               clp_pkg::ERR_NUMBER, n_line + 1'b1);
                                emit     = 1'b1;
                                n_mode   = n_second ? M_SKIP : M_HDR_PRE;
                                n_second = 1'b1;
                            end else if (n_acc == '0) begin
                                res = make_res(clp_pkg::KIND_CLAUSE_END, '0, 1'b0, '0,
                                               clp_pkg::ERR_NUMBER, n_line + 1'b1);
                                emit   = 1'b1;
                                n_mode = M_SKIP;
                            end else if ({1'b0, n_acc} > clp_pkg::VAR_LIMIT) begin
                                res = make_res(clp_pkg::KIND_ERROR, '0, 1'b0, '0,
                                               clp_pkg::ERR_VAR_RANGE, n_line + 1'b1);
                                emit     = 1'b1;
                                n_halted = 1'b1;
                            end else begin
                                var_full = n_acc - AB'(1);
                                res = make_res(clp_pkg::KIND_LITERAL, var_full[VB-1:0],
                                               n_neg, '0, clp_pkg::ERR_NUMBER,
                                               n_line + 1'b1);
                                emit   = 1'b1;
                                n_mode = M_CL_PRE;
                            end
                            n_acc = '0;
                            n_neg = 1'b0;
                            again = !n_halted;
                        end
                    end
                    M_SKIP: begin
                        if (cls == clp_pkg::CC_EOI) begin
                            n_line = n_line + 1'b1;
                            res = make_res(clp_pkg::KIND_CLEAN_END, '0, 1'b0, '0,
                                           clp_pkg::ERR_NUMBER, n_line + 1'b1);
                            emit     = 1'b1;
                            n_halted = 1'b1;
                        end else if (cls == clp_pkg::CC_NL) begin
                            n_line = n_line + 1'b1;
                            n_mode = M_LINE;
                        end
                    end
                    default: begin
                        n_mode = M_LINE;
                    end
                endcase
                // place the result in the next free slot
                if (emit) begin
                    if (n_count == 2'd0) begin
                        n_r0 = res;
                    end else begin
                        n_r1 = res;
                    end
                    n_count = n_count + 2'd1;
                end
            end
        end

        // mark the final result of this byte
        if (n_count == 2'd1) begin
            n_r0.last = 1'b1;
        end else if (n_count == 2'd2) begin
            n_r1.last = 1'b1;
        end
    end

    // take the next byte once both result slots can absorb it
    assign take     = r_out_valid && o_out.ready;
    assign can_take = !r_pend_valid && (!r_out_valid || o_out.ready);
    assign o_pop    = i_head.valid && can_take;

    // state and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= M_LINE;
            r_acc        <= '0;
            r_neg        <= 1'b0;
            r_pos        <= 3'd0;
            r_second     <= 1'b0;
            r_line       <= '0;
            r_halted     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mode   <= n_mode;
                r_acc    <= n_acc;
                r_neg    <= n_neg;
                r_pos    <= n_pos;
                r_second <= n_second;
                r_line   <= n_line;
                r_halted <= n_halted;
                if (n_count != 2'd0) begin
                    r_out       <= n_r0;
                    r_out_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b0;
                end
                if (n_count == 2'd2) begin
                    r_pend       <= n_r1;
                    r_pend_valid <= 1'b1;
                end
            end else if (r_pend_valid && (!r_out_valid || take)) begin
                r_out        <= r_pend;
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else if (take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_out.kind;
    assign o_out.var_index   = r_out.var_index;
    assign o_out.negated     = r_out.negated;
    assign o_out.count_value = r_out.count_value;
    assign o_out.error_code  = r_out.error_code;
    assign o_out.line_number = r_out.line_number;
    assign o_out.last        = r_out.last;

endmodule

`default_nettype wire

[design/cnf_text_literal_parser.sv]
// CNF text parser: one byte of DIMACS text in, literal / clause-end / header
// count / error / clean-end results out.
// i_in carries char_code and end_of_input; a transfer happens when valid and
// ready are both high. o_out carries one result per transfer; last marks the
// final result caused by a byte.
// Throughput: one byte per cycle while o_out takes results. A byte that causes two
// results (a number ending on a byte that also ends the stream or fails) holds the
// back end while the second result waits for the output register.
// A byte is registered in the classifier queue, and its result in the parser's
// output register, before the result can transfer. A two-entry queue between
// classifier and parser lets input keep flowing while a result waits; when o_out
// stalls, the queue fills and i_in.ready drops.
// After an error or a clean end the block keeps taking bytes but returns no
// results until reset. Reset (synchronous, active low) returns the parser to
// line start with line count zero and empties queue and output.
`default_nettype none

module cnf_text_literal_parser (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    clp_in_if.sink    i_in,
    clp_out_if.source o_out
);

    logic             push;
    logic             q_ready;
    logic             pop;
    clp_pkg::t_item   item;
    clp_pkg::t_q_head head;

    // byte classification
    clp_front u_front (
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_item    (item)
    );

    // decoupling queue
    clp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (item),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_head  (head)
    );

    // parse state machine and result output
    clp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

[tb/tb_cnf_text_literal_parser.sv]
`timescale 1ns / 1ps

module tb_cnf_text_literal_parser;

    localparam int ITEM_TARGET = 2000;
    localparam int HOLD_AT     = 300;   // bytes taken before the long output stall
    localparam int HOLD_CYCLES = 200;
    localparam int QUIET_LIMIT = 5000;  // cycles with no transfer before giving up
    localparam int END_WAIT    = 10;

    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] BLANK_CODES [5] = '{8'd9, 8'd11, 8'd12, 8'd13, 8'd32};
    localparam string      HDR_WORD = "p cnf";

    typedef enum logic [3:0] {
        PM_LINE,
        PM_HDR_MATCH,
        PM_HDR_PRE,
        PM_HDR_SIGNED,
        PM_HDR_DIGITS,
        PM_CL_PRE,
        PM_CL_SIGNED,
        PM_CL_DIGITS,
        PM_SKIP
    } t_parse_mode;

    typedef struct {
        logic [7:0] code;
        bit         eoi;
        bit         drain_first;  // hold this byte back until every result is in
    } t_text_byte;

    logic i_clk;
    logic i_rst_n;

    clp_in_if  in_bus ();
    clp_out_if out_bus ();

    cnf_text_literal_parser DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // bytes still to send and results still owed by the block
    t_text_byte       pending[$];
    clp_pkg::t_result expected_results[$];
    clp_pkg::t_result step_results[$];

    int    total_bytes     = 0;
    int    bytes_taken     = 0;
    int    results_checked = 0;
    int    fail_count      = 0;
    int    quiet_cycles    = 0;
    int    hold_left       = 0;
    bit    hold_done       = 0;
    string end_name;

    // parser state as the block should hold it
    t_parse_mode                   mode       = PM_LINE;
    logic [clp_pkg::ACC_BITS-1:0]  acc        = '0;
    logic                          acc_neg    = 1'b0;
    logic [2:0]                    hdr_pos    = '0;
    logic [1:0]                    hdr_done   = '0;
    logic [clp_pkg::LINE_BITS-1:0] line_cnt   = '0;
    bit                            halted     = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // queue append helpers
    function automatic void append_step(clp_pkg::t_result r);
        step_results = {step_results, r};
    endfunction

    function automatic void append_expected(clp_pkg::t_result r);
        expected_results = {expected_results, r};
    endfunction

    function automatic void append_pending(t_text_byte b);
        pending = {pending, b};
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        foreach (BLANK_CODES[i]) if (c == BLANK_CODES[i]) return 1;
        return 0;
    endfunction

    // a step yields at most two results
    function automatic void add_result(clp_pkg::t_kind k,
                                       logic [clp_pkg::VAR_INDEX_BITS-1:0] vi, logic ng,
                                       logic [clp_pkg::ACC_BITS-1:0] cnt, clp_pkg::t_err e);
        clp_pkg::t_result r;
        if (step_results.size() >= 2) return;
        r.kind        = k;
        r.var_index   = vi;
        r.negated     = ng;
        r.count_value = cnt;
        r.error_code  = e;
        r.line_number = line_cnt + 32'd1;
        r.last        = 1'b0;
        append_step(r);
    endfunction

    function automatic void raise_error(clp_pkg::t_err e);
        add_result(clp_pkg::KIND_ERROR, '0, 1'b0, '0, e);
        halted = 1;
    endfunction

    function automatic void clear_number();
        acc     = '0;
        acc_neg = 1'b0;
    endfunction

    // a number just ended: header count, clause end or literal
    function automatic void close_number(bit hdr);
        logic [clp_pkg::ACC_BITS-1:0] idx;
        if (hdr) begin
            add_result(hdr_done == 0 ? clp_pkg::KIND_HDR_VARS : clp_pkg::KIND_HDR_CLAUSES,
                       '0, 1'b0, acc_neg ? '0 : acc, clp_pkg::ERR_NUMBER);
            hdr_done++;
            mode = (hdr_done >= 2) ? PM_SKIP : PM_HDR_PRE;
        end else if (acc == 0) begin
            add_result(clp_pkg::KIND_CLAUSE_END, '0, 1'b0, '0, clp_pkg::ERR_NUMBER);
            mode = PM_SKIP;
        end else begin
            idx = acc - 1'b1;
            if (idx >= (clp_pkg::ACC_BITS'(1) << clp_pkg::VAR_INDEX_BITS)) begin
                raise_error(clp_pkg::ERR_VAR_RANGE);
            end else begin
                add_result(clp_pkg::KIND_LITERAL, idx[clp_pkg::VAR_INDEX_BITS-1:0], acc_neg,
                           '0, clp_pkg::ERR_NUMBER);
                mode = PM_CL_PRE;
            end
        end
        clear_number();
    endfunction

    // one pass over a byte; returns 1 when the byte must be seen again in the new mode
    function automatic bit parse_pass(logic [7:0] c, bit eoi);
        bit          hdr;
        bit          is_dig;
        logic [34:0] grown;
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
        case (mode)
            PM_LINE: begin
                if (eoi) begin
                    add_result(clp_pkg::KIND_CLEAN_END, '0, 1'b0, '0, clp_pkg::ERR_NUMBER);
                    halted = 1;
                end else if (is_blank(c)) begin
                end else if (c == CH_NL) begin
                    line_cnt++;
                end else if (c == CH_P) begin
                    mode    = PM_HDR_MATCH;
                    hdr_pos = 3'd1;
                end else if (c == CH_C) begin
                    mode = PM_SKIP;
                end else if (c == CH_X) begin
                    raise_error(clp_pkg::ERR_XOR);
                end else begin
                    mode = PM_CL_PRE;
                    clear_number();
                    return 1;
                end
                return 0;
            end
            PM_HDR_MATCH: begin
                if (eoi || hdr_pos >= clp_pkg::HDR_LEN || c != HDR_WORD[hdr_pos]) begin
                    raise_error(clp_pkg::ERR_HEADER);
                    return 0;
                end
                hdr_pos++;
                if (hdr_pos >= clp_pkg::HDR_LEN) begin
                    hdr_pos  = '0;
                    hdr_done = '0;
                    clear_number();
                    mode = PM_HDR_PRE;
                end
                return 0;
            end
            PM_HDR_PRE, PM_CL_PRE: begin
                hdr = (mode == PM_HDR_PRE);
                if (eoi) begin
                    raise_error(clp_pkg::ERR_NUMBER);
                end else if (is_blank(c)) begin
                end else if (c == CH_MINUS || c == CH_PLUS) begin
                    acc_neg = (c == CH_MINUS);
                    mode    = hdr ? PM_HDR_SIGNED : PM_CL_SIGNED;
                end else if (is_dig) begin
                    acc  = clp_pkg::ACC_BITS'(c - CH_ZERO);
                    mode = hdr ? PM_HDR_DIGITS : PM_CL_DIGITS;
                end else begin
                    raise_error(clp_pkg::ERR_NUMBER);
                end
                return 0;
            end
            PM_HDR_SIGNED, PM_CL_SIGNED: begin
                hdr = (mode == PM_HDR_SIGNED);
                if (!eoi && is_dig) begin
                    acc  = clp_pkg::ACC_BITS'(c - CH_ZERO);
                    mode = hdr ? PM_HDR_DIGITS : PM_CL_DIGITS;
                end else begin
                    raise_error(clp_pkg::ERR_NUMBER);
                end
                return 0;
            end
            PM_HDR_DIGITS, PM_CL_DIGITS: begin
                if (!eoi && is_dig) begin
                    // accumulate and saturate
                    grown = 35'(acc) * 35'd10 + 35'(c - CH_ZERO);
                    acc   = (grown > 35'(clp_pkg::ACC_MAX)) ? clp_pkg::ACC_MAX
                                                            : grown[clp_pkg::ACC_BITS-1:0];
                    return 0;
                end
                close_number(mode == PM_HDR_DIGITS);
                return !halted;
            end
            PM_SKIP: begin
                if (eoi) begin
                    line_cnt++;
                    add_result(clp_pkg::KIND_CLEAN_END, '0, 1'b0, '0, clp_pkg::ERR_NUMBER);
                    halted = 1;
                end else if (c == CH_NL) begin
                    line_cnt++;
                    mode = PM_LINE;
                end
                return 0;
            end
            default: begin
                mode = PM_LINE;
                return 1;
            end
        endcase
        return 0;
    endfunction

    // expected results of one accepted byte, last flag on the final one
    function automatic void predict_byte(logic [7:0] c, bit eoi);
        clp_pkg::t_result r;
        step_results.delete();
        for (int pass = 0; pass < 3 && !halted; pass++) begin
            if (!parse_pass(c, eoi)) break;
        end
        if (step_results.size() > 0) begin
            r      = step_results.pop_back();
            r.last = 1'b1;
            append_step(r);
        end
        foreach (step_results[i]) append_expected(step_results[i]);
    endfunction

    function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // idle share in percent for the current third of the stream
    function automatic int idle_pct(bit sender);
        if (bytes_taken * 3 < total_bytes) return sender ? 6 : 47;
        if (bytes_taken * 3 < total_bytes * 2) return sender ? 47 : 6;
        return 0;
    endfunction

    // stream building helpers
    function automatic void put_byte(logic [7:0] c, bit eoi = 0);
        t_text_byte b;
        b.code        = c;
        b.eoi         = eoi;
        b.drain_first = 0;
        append_pending(b);
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endfunction

    function automatic void put_blanks(int lo, int hi);
        int n;
        n = $urandom_range(hi, lo);
        repeat (n) begin
            if ($urandom_range(99) < 60) put_byte(BLANK_CODES[4]);
            else put_byte(BLANK_CODES[$urandom_range(4, 0)]);
        end
    endfunction

    // any bytes but newline
    function automatic void put_junk(int n);
        logic [7:0] c;
        repeat (n) begin
            do c = 8'($urandom_range(255, 0)); while (c == CH_NL);
            put_byte(c);
        end
    endfunction

    function automatic string digits_for(bit hdr);
        int unsigned r;
        r = $urandom_range(99);
        if (hdr && r < 15)
            return $sformatf("%0d%09d", $urandom_range(999, 3), $urandom_range(999999999, 0));
        if (hdr && r < 25) return "0";
        if (r < 60) return $sformatf("%0d", $urandom_range(30, 1));
        if (r < 75)
            return $sformatf("%0d", $urandom_range(1 << clp_pkg::VAR_INDEX_BITS, 1));
        if (r < 82) return $sformatf("%0d", 1 << clp_pkg::VAR_INDEX_BITS);
        if (r < 90) return $sformatf("00%0d", $urandom_range(9, 1));
        return $sformatf("%0d", $urandom_range(99999, 31));
    endfunction

    // a signed number may follow the previous one with no blank between
    function automatic void put_number(bit hdr, bit need_sep);
        int unsigned s;
        s = $urandom_range(99);
        if (s < 60) begin
            put_blanks(need_sep, 2);
        end else begin
            put_blanks(0, 2);
            put_byte(s < 88 ? CH_MINUS : CH_PLUS);
        end
        put_text(digits_for(hdr));
    endfunction

    function automatic void put_line_end();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 50) begin
            put_byte(CH_NL);
        end else if (r < 70) begin
            put_byte(CH_CR);
            put_byte(CH_NL);
        end else begin
            put_blanks(1, 1);
            put_junk($urandom_range(10, 0));
            put_byte(CH_NL);
        end
    endfunction

    // byte source: holds each byte until it is taken
    always @(posedge i_clk) begin : byte_source
        bit offer;
        if (!i_rst_n) begin
            in_bus.valid        <= 1'b0;
            in_bus.char_code    <= '0;
            in_bus.end_of_input <= 1'b0;
        end else begin
            offer = in_bus.valid;
            if (in_bus.valid && in_bus.ready) begin
                predict_byte(in_bus.char_code, in_bus.end_of_input);
                void'(pending.pop_front());
                bytes_taken++;
                offer = 0;
            end
            if (!offer && pending.size() > 0 && $urandom_range(99) >= idle_pct(1) &&
                (!pending[0].drain_first || expected_results.size() == 0)) begin
                offer = 1;
                in_bus.char_code    <= pending[0].code;
                in_bus.end_of_input <= pending[0].eoi;
            end
            in_bus.valid <= offer;
        end
    end

    // result sink: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_bus.ready <= 1'b0;
        end else if (!hold_done && bytes_taken >= HOLD_AT) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES - 1;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= ($urandom_range(99) >= idle_pct(0));
        end
    end

    // result checker
    always @(posedge i_clk) begin : result_check
        clp_pkg::t_result want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: kind %0d, line %0d", out_bus.kind,
                       out_bus.line_number);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                fail_count += field_diff("kind", want.kind, out_bus.kind);
                fail_count += field_diff("var_index", want.var_index, out_bus.var_index);
                fail_count += field_diff("negated", want.negated, out_bus.negated);
                fail_count += field_diff("count_value", want.count_value, out_bus.count_value);
                fail_count += field_diff("error_code", want.error_code, out_bus.error_code);
                fail_count += field_diff("line_number", want.line_number, out_bus.line_number);
                fail_count += field_diff("last", want.last, out_bus.last);
                results_checked++;
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int unsigned r;
        int          n;
        int          mark;
        t_text_byte  b;

        in_bus.valid        = 1'b0;
        in_bus.char_code    = '0;
        in_bus.end_of_input = 1'b0;
        out_bus.ready       = 1'b0;
        i_rst_n             = 1'b0;

        // directed: negative and saturated header counts, largest index, signs, minus zero
        put_text("p cnf -2 +9999999999");
        put_byte(CH_NL);
        put_text("268435456 1-2+3 -0");
        put_byte(CH_NL);

        // well-formed text with random content
        while (pending.size() < ITEM_TARGET) begin
            r = $urandom_range(99);
            if (r < 62) begin
                // clause line
                put_blanks(0, 1);
                n = $urandom_range(5, 0);
                for (int k = 0; k < n; k++) put_number(0, k != 0);
                case ($urandom_range(3, 0))
                    0: begin put_blanks(n != 0, 2); put_text("0"); end
                    1: begin put_blanks(0, 2); put_text("-0"); end
                    2: begin put_blanks(0, 2); put_text("+0"); end
                    default: begin put_blanks(n != 0, 2); put_text("00"); end
                endcase
                put_line_end();
            end else if (r < 74) begin
                // comment line with arbitrary bytes
                put_blanks(0, 2);
                put_byte(CH_C);
                put_junk($urandom_range(15, 0));
                put_byte(CH_NL);
            end else if (r < 88) begin
                // empty or blank-only line
                put_blanks(0, 3);
                put_byte(CH_NL);
            end else begin
                // header line
                put_blanks(0, 1);
                put_text(HDR_WORD);
                put_number(1, 0);
                put_number(1, 1);
                put_line_end();
            end
        end

        // halfway through, let the block drain completely
        mark = pending.size() / 2;
        b = pending[mark];
        b.drain_first = 1;
        pending[mark] = b;

        // one way to end the stream; the block halts after it
        mark = pending.size();
        case ($urandom_range(14, 0))
            0: begin
                end_name = "end of stream at line start";
                put_byte(8'($urandom_range(255, 0)), 1);
            end
            1: begin
                end_name = "end of stream inside a comment";
                put_byte(CH_C);
                put_junk(5);
                put_byte(8'($urandom_range(255, 0)), 1);
            end
            2: begin
                end_name = "end of stream right after a clause end";
                put_text("5 0");
                put_byte(8'($urandom_range(255, 0)), 1);
            end
            3: begin
                end_name = "end of stream inside a literal";
                put_text("5 7");
                put_byte(8'($urandom_range(255, 0)), 1);
            end
            4: begin
                end_name = "end of stream after a sign";
                put_text("5 -");
                put_byte(8'($urandom_range(255, 0)), 1);
            end
            5: begin
                end_name = "xor clause";
                put_text("x 1 2 0");
                put_byte(CH_NL);
            end
            6: begin
                end_name = "misspelled header";
                put_text("p cxf 1 1");
                put_byte(CH_NL);
            end
            7: begin
                end_name = "end of stream inside the header keyword";
                put_text("p cn");
                put_byte(8'($urandom_range(255, 0)), 1);
            end
            8: begin
                end_name = "variable index one past the range";
                put_text("268435457 0");
                put_byte(CH_NL);
            end
            9: begin
                end_name = "saturated variable";
                put_text("99999999999 0");
                put_byte(CH_NL);
            end
            10: begin
                end_name = "clause broken by a newline";
                put_text("3 4");
                put_byte(CH_NL);
            end
            11: begin
                end_name = "letter where a number is due";
                put_text("3 a 0");
                put_byte(CH_NL);
            end
            12: begin
                end_name = "zero byte at line start";
                put_byte(8'h00);
                put_byte(CH_NL);
            end
            13: begin
                end_name = "end of stream after a complete header";
                put_text("p cnf 3 4");
                put_byte(8'($urandom_range(255, 0)), 1);
            end
            default: begin
                end_name = "header missing its clause count";
                put_text("p cnf 2");
                put_byte(CH_NL);
            end
        endcase
        b = pending[mark];
        b.drain_first = 1;
        pending[mark] = b;

        // bytes after the halt must produce nothing
        repeat (4) put_byte(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));

        total_bytes = pending.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || in_bus.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (END_WAIT) @(posedge i_clk);

        $display("parsed %0d bytes of CNF text, checked %0d results", bytes_taken,
                 results_checked);
        $display("stream ended with: %s", end_name);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
